// ----- src/sti_pkg.sv -----
// sti_pkg: shared constants and hit class codes for the segment/triangle intersect block
// no dependencies; imported by sti_out_if, the top level and the testbench
`timescale 1ns / 1ps

package sti_pkg;

	localparam int COORD_BITS_DEF       = 21;
	localparam int WEIGHT_FRAC_BITS_DEF = 30;
	localparam int POINT_FRAC_BITS      = 16;

	// register stages inside one orientation unit
	localparam int ORIENT_LAT = 6;

	typedef enum logic [3:0] {
		HIT_NONE     = 4'd0,
		HIT_DEGEN    = 4'd1,
		HIT_INTERIOR = 4'd2,
		HIT_EDGE_AB  = 4'd3,
		HIT_EDGE_BC  = 4'd4,
		HIT_EDGE_CA  = 4'd5,
		HIT_NODE_A   = 4'd6,
		HIT_NODE_B   = 4'd7,
		HIT_NODE_C   = 4'd8,
		HIT_COPLANAR = 4'd9
	} hit_class_t;

endpackage

// ----- src/sti_in_if.sv -----
// sti_in_if: query channel, triangle and segment end points
// plain valid/ready handshake, no package dependency
`timescale 1ns / 1ps

interface sti_in_if;
	logic        valid;
	logic        ready;
	logic [62:0] vertex_a;
	logic [62:0] vertex_b;
	logic [62:0] vertex_c;
	logic [62:0] seg_start;
	logic [62:0] seg_end;

	modport source (output valid, vertex_a, vertex_b, vertex_c, seg_start, seg_end,
		input ready);
	modport sink (input valid, vertex_a, vertex_b, vertex_c, seg_start, seg_end,
		output ready);
endinterface

// ----- src/sti_out_if.sv -----
// sti_out_if: result channel, hit class, barycentric weights and hit point
// plain valid/ready handshake, hit class typed from sti_pkg
`timescale 1ns / 1ps

interface sti_out_if
	import sti_pkg::*;
;
	logic               valid;
	logic               ready;
	hit_class_t         hit_class;
	logic signed [33:0] weight_a;
	logic signed [33:0] weight_b;
	logic signed [33:0] weight_c;
	logic signed [36:0] hit_x;
	logic signed [36:0] hit_y;
	logic signed [36:0] hit_z;

	modport source (output valid, hit_class, weight_a, weight_b, weight_c, hit_x, hit_y,
		hit_z, input ready);
	modport sink (input valid, hit_class, weight_a, weight_b, weight_c, hit_x, hit_y,
		hit_z, output ready);
endinterface

// ----- src/segment_triangle_intersect_top.sv -----
// segment_triangle_intersect_top: exact segment/triangle intersection pipeline
// depends on sti_pkg, sti_in_if, sti_out_if, sti_orient, sti_mul and sti_div
`timescale 1ns / 1ps

// One query (triangle a, b, c and segment start, end, three signed COORD_BITS
// coordinates per point, x lowest) enters per cycle and gives exactly one result:
// hit class, barycentric weights of a and b (WEIGHT_FRAC_BITS fraction bits, c takes
// one minus the other two) and the hit point with 16 fraction bits, all rounded to
// nearest with ties away from zero. Orientation determinants are exact, so edge and
// node hits are exact zero tests. Weights and point read zero unless the segment hits.
// The five restoring dividers give QB = max(WEIGHT_FRAC_BITS + 1, COORD_BITS + 16)
// quotient bits, one quotient bit per stage; the six stage orientation units and
// four stages of classify, multiply and operand setup come before them. Throughput
// is one transfer per cycle; the pipeline stops only when its last stage is full and
// the result register waits on the sink.

module segment_triangle_intersect_top
	import sti_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	sti_in_if.sink  query,
	sti_out_if.source result
);
	localparam int CB   = COORD_BITS;
	localparam int WF   = WEIGHT_FRAC_BITS;
	localparam int PF   = POINT_FRAC_BITS;
	localparam int DETW = 3 * CB + 6;
	localparam int SW   = DETW + 2;
	localparam int PMW  = DETW + CB;
	localparam int PNW  = PMW + 2;
	localparam int QB   = (WF + 1 > CB + PF) ? WF + 1 : CB + PF;
	localparam int WNW  = DETW + WF + 2;
	localparam int PXW  = PNW + PF + 2;
	localparam int DVW  = SW + 1;
	localparam int NWA  = (WNW > PXW) ? WNW : PXW;
	localparam int NW   = (NWA > DVW + QB) ? NWA : DVW + QB;
	localparam int PTW  = 9 * CB + 1;
	localparam int PIPE = ORIENT_LAT + 4 + QB;

	// ---------------------------------------------------------------
	// flow control: every stage moves unless the last one is blocked
	// ---------------------------------------------------------------
	logic            en;
	logic [PIPE-1:0] v_q;
	logic            out_v_q;

	assign en = !(v_q[PIPE-1] && out_v_q && !result.ready);
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (en) v_q <= {v_q[PIPE-2:0], query.valid};
			if (en && v_q[PIPE-1]) out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// unpack and orientation units
	// ---------------------------------------------------------------
	logic [3*CB-1:0] pa, pb, pc, ps, pe;

	assign pa = query.vertex_a[3*CB-1:0];
	assign pb = query.vertex_b[3*CB-1:0];
	assign pc = query.vertex_c[3*CB-1:0];
	assign ps = query.seg_start[3*CB-1:0];
	assign pe = query.seg_end[3*CB-1:0];

	logic signed [DETW-1:0] o_s, o_e, d12, d23, d31;

	sti_orient #(.CB (CB)) u_or_s (.clk (clk), .en (en), .p (pa), .q (pb), .r (pc),
		.s (ps), .det (o_s));
	sti_orient #(.CB (CB)) u_or_e (.clk (clk), .en (en), .p (pa), .q (pb), .r (pc),
		.s (pe), .det (o_e));
	sti_orient #(.CB (CB)) u_or_12 (.clk (clk), .en (en), .p (pa), .q (pb), .r (ps),
		.s (pe), .det (d12));
	sti_orient #(.CB (CB)) u_or_23 (.clk (clk), .en (en), .p (pb), .q (pc), .r (ps),
		.s (pe), .det (d23));
	sti_orient #(.CB (CB)) u_or_31 (.clk (clk), .en (en), .p (pc), .q (pa), .r (ps),
		.s (pe), .det (d31));

	// vertices and the degenerate segment flag ride alongside the orientation units
	logic [PTW-1:0] pt_d [ORIENT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			pt_d[0] <= {(ps == pe), pc, pb, pa};
			for (int k = 1; k < ORIENT_LAT; k++) pt_d[k] <= pt_d[k-1];
		end
	end

	logic [PTW-1:0] pt6;
	logic           deg6;

	assign pt6  = pt_d[ORIENT_LAT-1];
	assign deg6 = pt6[9*CB];

	// ---------------------------------------------------------------
	// stage 7: classify, determinant sum
	// ---------------------------------------------------------------
	hit_class_t cls_n;
	logic       z12, z23, z31, n12, n23, n31, same_side;

	always_comb begin
		z12 = (d12 == '0);
		z23 = (d23 == '0);
		z31 = (d31 == '0);
		n12 = d12[DETW-1];
		n23 = d23[DETW-1];
		n31 = d31[DETW-1];
		same_side = (o_s != '0) && (o_e != '0) && (o_s[DETW-1] == o_e[DETW-1]);
		if (deg6)
			cls_n = HIT_DEGEN;
		else if (same_side)
			cls_n = HIT_NONE;
		else if (!((!n12 && !n23 && !n31) || ((n12 || z12) && (n23 || z23) && (n31 || z31))))
			cls_n = HIT_NONE;
		else if (z12)
			cls_n = z23 ? (z31 ? HIT_COPLANAR : HIT_NODE_B) : (z31 ? HIT_NODE_A : HIT_EDGE_AB);
		else if (z23)
			cls_n = z31 ? HIT_NODE_C : HIT_EDGE_BC;
		else if (z31)
			cls_n = HIT_EDGE_CA;
		else
			cls_n = HIT_INTERIOR;
	end

	hit_class_t           cls_s7, cls_s8, cls_s9, cls_s10;
	logic                 zero_s7, zero_s8, zero_s9, zero_s10;
	logic signed [SW-1:0] sum_s7, sum_s8, sum_s9;
	logic signed [DETW-1:0] d23_s7, d23_s8, d23_s9, d31_s7, d31_s8, d31_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s7  <= cls_n;
			// weights and point only for an actual hit with nonzero sum
			zero_s7 <= !(cls_n inside {[HIT_INTERIOR:HIT_NODE_C]});
			sum_s7  <= SW'(d12) + SW'(d23) + SW'(d31);
			d23_s7  <= d23;
			d31_s7  <= d31;
			cls_s8  <= cls_s7;
			zero_s8 <= zero_s7;
			sum_s8  <= sum_s7;
			d23_s8  <= d23_s7;
			d31_s8  <= d31_s7;
		end
	end

	// ---------------------------------------------------------------
	// stages 7-8: determinant times vertex coordinate products
	// ---------------------------------------------------------------
	logic signed [PMW-1:0] ma [3], mb [3], mc [3];

	for (genvar i = 0; i < 3; i++) begin : g_coord
		sti_mul #(.AW (DETW), .BW (CB), .CH ((DETW + 2) / 3)) u_ma (
			.clk (clk), .en (en), .a (d23), .b ($signed(pt6[i*CB +: CB])), .p (ma[i]));
		sti_mul #(.AW (DETW), .BW (CB), .CH ((DETW + 2) / 3)) u_mb (
			.clk (clk), .en (en), .a (d31), .b ($signed(pt6[(3+i)*CB +: CB])), .p (mb[i]));
		sti_mul #(.AW (DETW), .BW (CB), .CH ((DETW + 2) / 3)) u_mc (
			.clk (clk), .en (en), .a (d12), .b ($signed(pt6[(6+i)*CB +: CB])), .p (mc[i]));
	end

	// ---------------------------------------------------------------
	// stage 9: point numerators
	// ---------------------------------------------------------------
	logic signed [PNW-1:0] pn_s9 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pn_s9[i] <= PNW'(ma[i]) + PNW'(mb[i]) + PNW'(mc[i]);
			cls_s9  <= cls_s8;
			zero_s9 <= zero_s8;
			sum_s9  <= sum_s8;
			d23_s9  <= d23_s8;
			d31_s9  <= d31_s8;
		end
	end

	// ---------------------------------------------------------------
	// stage 10: divider operands, (2|n| + |S|) / (2|S|) rounds half away from zero
	// ---------------------------------------------------------------
	logic [SW-1:0]   abs_sum;
	logic [DETW-1:0] abs_d23, abs_d31;
	logic [PNW-1:0]  abs_pn [3];
	logic [NW-1:0]   num_n [5];
	logic [4:0]      neg_n;

	always_comb begin
		abs_sum = sum_s9[SW-1] ? SW'(-sum_s9) : SW'(sum_s9);
		abs_d23 = d23_s9[DETW-1] ? DETW'(-d23_s9) : DETW'(d23_s9);
		abs_d31 = d31_s9[DETW-1] ? DETW'(-d31_s9) : DETW'(d31_s9);
		num_n[0] = (NW'(abs_d23) << (WF + 1)) + NW'(abs_sum);
		num_n[1] = (NW'(abs_d31) << (WF + 1)) + NW'(abs_sum);
		neg_n[0] = d23_s9[DETW-1] ^ sum_s9[SW-1];
		neg_n[1] = d31_s9[DETW-1] ^ sum_s9[SW-1];
		for (int i = 0; i < 3; i++) begin
			abs_pn[i]    = pn_s9[i][PNW-1] ? PNW'(-pn_s9[i]) : PNW'(pn_s9[i]);
			num_n[2+i]   = (NW'(abs_pn[i]) << (PF + 1)) + NW'(abs_sum);
			neg_n[2+i]   = pn_s9[i][PNW-1] ^ sum_s9[SW-1];
		end
	end

	logic [NW-1:0]  num_s10 [5];
	logic [DVW-1:0] den_s10;
	logic [4:0]     neg_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s10  <= num_n;
			den_s10  <= {abs_sum, 1'b0};
			neg_s10  <= neg_n;
			cls_s10  <= cls_s9;
			zero_s10 <= zero_s9;
		end
	end

	// ---------------------------------------------------------------
	// dividers: weights a, b and point x, y, z
	// ---------------------------------------------------------------
	logic [QB-1:0] quo [5];

	for (genvar j = 0; j < 5; j++) begin : g_div
		sti_div #(.NW (NW), .DW (DVW), .QB (QB)) u_div (
			.clk (clk), .en (en), .num (num_s10[j]), .den (den_s10), .quo (quo[j]));
	end

	hit_class_t cls_d  [QB];
	logic       zero_d [QB];
	logic [4:0] neg_d  [QB];

	always_ff @(posedge clk) begin
		if (en) begin
			cls_d[0]  <= cls_s10;
			zero_d[0] <= zero_s10;
			neg_d[0]  <= neg_s10;
			for (int k = 1; k < QB; k++) begin
				cls_d[k]  <= cls_d[k-1];
				zero_d[k] <= zero_d[k-1];
				neg_d[k]  <= neg_d[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// result assembly and output register
	// ---------------------------------------------------------------
	logic signed [QB:0]   sq [5];
	logic signed [33:0]   wa_n, wb_n, wc_n;
	logic signed [36:0]   hx_n, hy_n, hz_n;

	always_comb begin
		for (int j = 0; j < 5; j++)
			sq[j] = neg_d[QB-1][j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
		if (zero_d[QB-1]) begin
			wa_n = '0;
			wb_n = '0;
			wc_n = '0;
			hx_n = '0;
			hy_n = '0;
			hz_n = '0;
		end else begin
			wa_n = 34'(sq[0]);
			wb_n = 34'(sq[1]);
			wc_n = (34'sd1 <<< WF) - wa_n - wb_n;
			hx_n = 37'(sq[2]);
			hy_n = 37'(sq[3]);
			hz_n = 37'(sq[4]);
		end
	end

	hit_class_t         hit_class_q;
	logic signed [33:0] weight_a_q, weight_b_q, weight_c_q;
	logic signed [36:0] hit_x_q, hit_y_q, hit_z_q;

	always_ff @(posedge clk) begin
		if (en && v_q[PIPE-1]) begin
			hit_class_q <= cls_d[QB-1];
			weight_a_q  <= wa_n;
			weight_b_q  <= wb_n;
			weight_c_q  <= wc_n;
			hit_x_q     <= hx_n;
			hit_y_q     <= hy_n;
			hit_z_q     <= hz_n;
		end
	end

	assign result.valid     = out_v_q;
	assign result.hit_class = hit_class_q;
	assign result.weight_a  = weight_a_q;
	assign result.weight_b  = weight_b_q;
	assign result.weight_c  = weight_c_q;
	assign result.hit_x     = hit_x_q;
	assign result.hit_y     = hit_y_q;
	assign result.hit_z     = hit_z_q;

endmodule

// ----- src/sti_mul.sv -----
// sti_mul: two stage signed multiplier, operand a cut into chunks of CH bits
// stage one registers the partial products, stage two their shifted sum; no dependencies
`timescale 1ns / 1ps

module sti_mul #(
	parameter int AW = 45,
	parameter int BW = 22,
	parameter int CH = 23
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	localparam int N  = (AW + CH - 1) / CH;
	localparam int XW = N * CH;
	localparam int PW = CH + BW + 1;
	localparam int OW = AW + BW;

	logic signed [XW-1:0] ax;
	logic signed [PW-1:0] part_s1 [N];
	logic signed [OW-1:0] acc;
	logic signed [OW-1:0] p_s2;

	assign ax = XW'(a);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				// top chunk carries the sign, lower chunks are unsigned
				if (i == N - 1)
					part_s1[i] <= $signed(ax[i*CH +: CH]) * b;
				else
					part_s1[i] <= $signed({1'b0, ax[i*CH +: CH]}) * b;
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < N; i++)
			acc = acc + (OW'(part_s1[i]) <<< (i * CH));
	end

	always_ff @(posedge clk) begin
		if (en) p_s2 <= acc;
	end

	assign p = p_s2;

endmodule

// ----- src/sti_orient.sv -----
// sti_orient: exact 3x3 orientation determinant of rows p-s, q-s, r-s, six stages
// depends on sti_mul for the cross product times row terms
`timescale 1ns / 1ps

module sti_orient #(
	parameter int CB = 21
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3*CB-1:0]       p,
	input  logic [3*CB-1:0]       q,
	input  logic [3*CB-1:0]       r,
	input  logic [3*CB-1:0]       s,
	output logic signed [3*CB+5:0] det
);
	localparam int DW   = CB + 1;
	localparam int CPW  = 2 * DW + 1;
	localparam int TW   = CPW + DW;
	localparam int DETW = 3 * CB + 6;

	logic signed [CB-1:0]    pc [3], qc [3], rc [3], sc [3];
	logic signed [DW-1:0]    pd_s1 [3], qd_s1 [3], rd_s1 [3];
	logic signed [2*DW-1:0]  pr_s2 [6];
	logic signed [DW-1:0]    pd_s2 [3];
	logic signed [CPW-1:0]   cr_s3 [3];
	logic signed [DW-1:0]    pd_s3 [3];
	logic signed [TW-1:0]    t_s5 [3];
	logic signed [DETW-1:0]  det_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pc[i] = $signed(p[i*CB +: CB]);
			qc[i] = $signed(q[i*CB +: CB]);
			rc[i] = $signed(r[i*CB +: CB]);
			sc[i] = $signed(s[i*CB +: CB]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s1[i] <= DW'(pc[i]) - DW'(sc[i]);
				qd_s1[i] <= DW'(qc[i]) - DW'(sc[i]);
				rd_s1[i] <= DW'(rc[i]) - DW'(sc[i]);
			end
			// cross product terms of rows q and r
			pr_s2[0] <= qd_s1[1] * rd_s1[2];
			pr_s2[1] <= qd_s1[2] * rd_s1[1];
			pr_s2[2] <= qd_s1[2] * rd_s1[0];
			pr_s2[3] <= qd_s1[0] * rd_s1[2];
			pr_s2[4] <= qd_s1[0] * rd_s1[1];
			pr_s2[5] <= qd_s1[1] * rd_s1[0];
			pd_s2    <= pd_s1;
			cr_s3[0] <= CPW'(pr_s2[0]) - CPW'(pr_s2[1]);
			cr_s3[1] <= CPW'(pr_s2[2]) - CPW'(pr_s2[3]);
			cr_s3[2] <= CPW'(pr_s2[4]) - CPW'(pr_s2[5]);
			pd_s3    <= pd_s2;
			det_s6   <= DETW'(t_s5[0]) + DETW'(t_s5[1]) + DETW'(t_s5[2]);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_term
		sti_mul #(
			.AW (CPW),
			.BW (DW),
			.CH ((CPW + 1) / 2)
		) u_mul (
			.clk (clk),
			.en  (en),
			.a   (cr_s3[k]),
			.b   (pd_s3[k]),
			.p   (t_s5[k])
		);
	end

	assign det = det_s6;

endmodule

// ----- src/sti_div.sv -----
// sti_div: pipelined restoring divider, one quotient bit per register stage
// numerator must stay below den * 2^QB; no dependencies
`timescale 1ns / 1ps

module sti_div #(
	parameter int NW = 110,
	parameter int DW = 72,
	parameter int QB = 37
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo
);
	logic [NW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	logic [NW-1:0] rin [QB];
	logic [NW-1:0] rnx [QB];
	logic [DW-1:0] din [QB];
	logic [QB-1:0] qin [QB];
	logic [QB-1:0] qnx [QB];
	logic [NW:0]   dif [QB];

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				rin[k] = num;
				din[k] = den;
				qin[k] = '0;
			end else begin
				rin[k] = rem_s[k-1];
				din[k] = den_s[k-1];
				qin[k] = quo_s[k-1];
			end
			// trial subtract of the shifted divisor, borrow means bit stays clear
			dif[k] = {1'b0, rin[k]} - {1'b0, NW'(din[k]) << (QB - 1 - k)};
			rnx[k] = dif[k][NW] ? rin[k] : dif[k][NW-1:0];
			qnx[k] = dif[k][NW] ? qin[k] : (qin[k] | (QB'(1) << (QB - 1 - k)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_s[k] <= rnx[k];
				den_s[k] <= din[k];
				quo_s[k] <= qnx[k];
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for segment_triangle_intersect_top
// depends on sti_pkg, sti_in_if, sti_out_if and the top level under src
`timescale 1ns / 1ps

module testbench;
	import sti_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef wide_t point_t [3];

	typedef struct packed {
		logic [62:0] vertex_a;
		logic [62:0] vertex_b;
		logic [62:0] vertex_c;
		logic [62:0] seg_start;
		logic [62:0] seg_end;
	} query_t;

	typedef struct packed {
		hit_class_t         hit_class;
		logic signed [33:0] weight_a;
		logic signed [33:0] weight_b;
		logic signed [33:0] weight_c;
		logic signed [36:0] hit_x;
		logic signed [36:0] hit_y;
		logic signed [36:0] hit_z;
	} hit_t;

	localparam int CB         = COORD_BITS_DEF;
	localparam int WF         = WEIGHT_FRAC_BITS_DEF;
	localparam int N_RANDOM   = 1300;
	localparam int PAUSE_AT   = 650;
	localparam int HOLD_AT    = 150;
	localparam int HOLD_LEN   = 400;
	// query transfer to result valid, plus margin
	localparam int DRAIN_WAIT = 120;
	localparam int C_MAX      = (1 << (CB - 1)) - 1;
	localparam int C_MIN      = -(1 << (CB - 1));

	logic clk;
	logic arst_n;

	sti_in_if  query ();
	sti_out_if result ();

	segment_triangle_intersect_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query.sink),
		.result(result.source)
	);

	// stimulus store, expected hits, bookkeeping
	query_t pending_queries[$];
	hit_t   expected_hits[$];
	int     n_total;
	int     n_taken;
	int     n_errors;
	int     phase;
	logic   took;
	logic   long_hold;
	logic   pause_done;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ---------------------------------------------------------------- geometry

	function automatic point_t unpack_point(logic [62:0] v);
		point_t p;
		for (int i = 0; i < 3; i++)
			p[i] = wide_t'($signed(v[i*CB +: CB]));
		return p;
	endfunction

	function automatic logic [62:0] pack_point(int x, int y, int z);
		logic [31:0] ux, uy, uz;
		ux = x;
		uy = y;
		uz = z;
		return {uz[CB-1:0], uy[CB-1:0], ux[CB-1:0]};
	endfunction

	function automatic int sgn(wide_t v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	// determinant of rows p-s, q-s, r-s
	function automatic wide_t orient(point_t p, point_t q, point_t r, point_t s);
		wide_t px, py, pz, qx, qy, qz, rx, ry, rz;
		px = p[0] - s[0]; py = p[1] - s[1]; pz = p[2] - s[2];
		qx = q[0] - s[0]; qy = q[1] - s[1]; qz = q[2] - s[2];
		rx = r[0] - s[0]; ry = r[1] - s[1]; rz = r[2] - s[2];
		return (qy*rz - qz*ry)*px + (qz*rx - qx*rz)*py + (qx*ry - qy*rx)*pz;
	endfunction

	// rounded quotient, ties away from zero, magnitude kept to 47 bits
	function automatic wide_t round_div(wide_t num, wide_t den);
		wide_t n, d, q, mag;
		n   = (num < 0) ? -num : num;
		d   = (den < 0) ? -den : den;
		q   = (2*n + d) / (2*d);
		mag = {81'd0, q[46:0]};
		return ((num < 0) != (den < 0)) ? -mag : mag;
	endfunction

	function automatic hit_t predict_hit(query_t qy);
		point_t a, b, c, s, e;
		wide_t d12, d23, d31, sum, wa, wb, wc, num;
		wide_t pt [3];
		int s12, s23, s31;
		hit_t h;
		a = unpack_point(qy.vertex_a);
		b = unpack_point(qy.vertex_b);
		c = unpack_point(qy.vertex_c);
		s = unpack_point(qy.seg_start);
		e = unpack_point(qy.seg_end);
		wa = 0; wb = 0; wc = 0;
		for (int i = 0; i < 3; i++) pt[i] = 0;
		h.hit_class = HIT_NONE;
		if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2]) begin
			h.hit_class = HIT_DEGEN;
		end else if (sgn(orient(a, b, c, s)) * sgn(orient(a, b, c, e)) <= 0) begin
			d12 = orient(a, b, s, e);
			d23 = orient(b, c, s, e);
			d31 = orient(c, a, s, e);
			s12 = sgn(d12); s23 = sgn(d23); s31 = sgn(d31);
			if ((s12 <= 0 && s23 <= 0 && s31 <= 0) || (s12 >= 0 && s23 >= 0 && s31 >= 0)) begin
				sum = d12 + d23 + d31;
				if (sum != 0) begin
					wa = round_div(d23 <<< WF, sum);
					wb = round_div(d31 <<< WF, sum);
					wc = (wide_t'(1) <<< WF) - wa - wb;
					for (int i = 0; i < 3; i++) begin
						num   = d23*a[i] + d31*b[i] + d12*c[i];
						pt[i] = round_div(num <<< POINT_FRAC_BITS, sum);
					end
				end
				// exact zero tests pick edge or node
				if (s12 == 0) begin
					if (s23 == 0) h.hit_class = (s31 == 0) ? HIT_COPLANAR : HIT_NODE_B;
					else h.hit_class = (s31 == 0) ? HIT_NODE_A : HIT_EDGE_AB;
				end else if (s23 == 0) begin
					h.hit_class = (s31 == 0) ? HIT_NODE_C : HIT_EDGE_BC;
				end else if (s31 == 0) begin
					h.hit_class = HIT_EDGE_CA;
				end else begin
					h.hit_class = HIT_INTERIOR;
				end
			end
		end
		h.weight_a = wa[33:0];
		h.weight_b = wb[33:0];
		h.weight_c = wc[33:0];
		h.hit_x    = pt[0][36:0];
		h.hit_y    = pt[1][36:0];
		h.hit_z    = pt[2][36:0];
		return h;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic query_t make_query(logic [62:0] a, logic [62:0] b, logic [62:0] c,
		logic [62:0] s, logic [62:0] e);
		query_t qy;
		qy.vertex_a  = a;
		qy.vertex_b  = b;
		qy.vertex_c  = c;
		qy.seg_start = s;
		qy.seg_end   = e;
		return qy;
	endfunction

	function automatic int rnd_coord();
		return int'($urandom_range(1 << 18)) - (1 << 17);
	endfunction

	function automatic logic [62:0] rnd_word();
		return 63'({$urandom, $urandom});
	endfunction

	// random query; most are shaped so the segment runs through a known point
	function automatic query_t random_query();
		int a [3], b [3], c [3], s [3], e [3], k, pick;
		int v [3];
		for (int i = 0; i < 3; i++) begin
			a[i] = rnd_coord(); b[i] = rnd_coord(); c[i] = rnd_coord();
			s[i] = rnd_coord();
		end
		k    = $urandom_range(99);
		pick = $urandom_range(2);
		for (int i = 0; i < 3; i++) v[i] = (pick == 0) ? a[i] : ((pick == 1) ? b[i] : c[i]);
		for (int i = 0; i < 3; i++) begin
			if (k < 40)      e[i] = a[i] + b[i] + c[i] - 2*s[i];   // through the centroid
			else if (k < 55) e[i] = (pick == 0) ? a[i] + b[i] - s[i]
				: ((pick == 1) ? b[i] + c[i] - s[i] : c[i] + a[i] - s[i]);   // edge midpoint
			else if (k < 67) e[i] = 2*v[i] - s[i];                // through a vertex
			else if (k < 77) begin                                // in the triangle plane
				s[i] = a[i] + b[i] - c[i];
				e[i] = b[i] + c[i] - a[i];
			end else if (k < 80) e[i] = s[i];                     // degenerate
			else e[i] = s[i] + rnd_coord();
		end
		if (k >= 85)
			return make_query(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
		return make_query(pack_point(a[0], a[1], a[2]), pack_point(b[0], b[1], b[2]),
			pack_point(c[0], c[1], c[2]), pack_point(s[0], s[1], s[2]),
			pack_point(e[0], e[1], e[2]));
	endfunction

	initial begin
		logic [62:0] ta, tb, tc;
		ta = pack_point(0, 0, 0);
		tb = pack_point(100, 0, 0);
		tc = pack_point(0, 100, 0);
		// degenerate segment, same side, interior, each edge, each node
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(10, 10, 5), pack_point(10, 10, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(10, 10, 5), pack_point(10, 10, 9)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(10, 10, -5), pack_point(10, 10, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(50, 0, -5), pack_point(50, 0, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(50, 50, -5), pack_point(50, 50, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(0, 50, -5), pack_point(0, 50, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(0, 0, -5), pack_point(0, 0, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(100, 0, -5), pack_point(100, 0, 5)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(0, 100, -5), pack_point(0, 100, 5)));
		// plane crossed outside the triangle gives mixed signs
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(200, 200, -5), pack_point(200, 200, 5)));
		// segment lying in the plane, inside and outside
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(10, 10, 0), pack_point(20, 20, 0)));
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(200, 0, 0), pack_point(300, 0, 0)));
		// one end touching the plane, and a crossing with the vertex order reversed
		pending_queries.push_back(make_query(ta, tb, tc,
			pack_point(10, 10, 0), pack_point(10, 10, 5)));
		pending_queries.push_back(make_query(ta, tc, tb,
			pack_point(33, 17, 7), pack_point(-3, 21, -11)));
		// coordinate extremes
		pending_queries.push_back(make_query(pack_point(C_MIN, C_MIN, C_MIN),
			pack_point(C_MAX, C_MIN, C_MIN), pack_point(C_MIN, C_MAX, C_MIN),
			pack_point(C_MIN, C_MIN, C_MAX), pack_point(C_MAX, C_MAX, C_MIN)));
		pending_queries.push_back(make_query(pack_point(C_MIN, C_MIN, 0),
			pack_point(C_MAX, C_MIN, 0), pack_point(C_MIN, C_MAX, 0),
			pack_point(-1000, -1000, C_MIN), pack_point(-1000, -1000, C_MAX)));
		pending_queries.push_back(make_query('1, '1, '1, '1, '0));
		pending_queries.push_back(make_query('0, {63{1'b1}} >> 1, {1'b1, 62'd0}, '0, '1));
		for (int i = 0; i < N_RANDOM; i++) pending_queries.push_back(random_query());
		n_total = pending_queries.size();
	end

	// ---------------------------------------------------------------- reset and control

	initial begin
		query.valid     = 1'b0;
		query.vertex_a  = '0;
		query.vertex_b  = '0;
		query.vertex_c  = '0;
		query.seg_start = '0;
		query.seg_end   = '0;
		result.ready    = 1'b0;
		took            = 1'b0;
		long_hold       = 1'b0;
		pause_done      = 1'b0;
		n_taken         = 0;
		n_errors        = 0;
		arst_n          = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
	end

	// idling pattern moves through four phases as the run goes on
	always_comb phase = (n_total == 0) ? 0 : (n_taken * 4) / n_total;

	// long receiver hold-off while the sender keeps offering, so the pipe backs up
	initial begin
		wait (arst_n && n_taken >= HOLD_AT);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		long_hold = 1'b0;
	end

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		logic idle_now;
		logic pause_now;
		if (arst_n) begin
			idle_now  = (phase == 1) ? ($urandom_range(99) < 67)
				: ((phase == 3) ? ($urandom_range(99) < 37) : 1'b0);
			// sender waits once for every outstanding result to drain
			pause_now = !pause_done && n_taken == PAUSE_AT;
			if (pause_now && expected_hits.size() == 0)
				pause_done <= 1'b1;
			if (!query.valid || took) begin
				if (pending_queries.size() > 0 && !idle_now && !pause_now) begin
					query_t qy;
					qy = pending_queries.pop_front();
					query.vertex_a  <= qy.vertex_a;
					query.vertex_b  <= qy.vertex_b;
					query.vertex_c  <= qy.vertex_c;
					query.seg_start <= qy.seg_start;
					query.seg_end   <= qy.seg_end;
					query.valid     <= 1'b1;
				end else begin
					query.valid <= 1'b0;
				end
			end
			result.ready <= !long_hold && !(((phase == 2) && ($urandom_range(99) < 67))
				|| ((phase == 3) && ($urandom_range(99) < 37)));
		end
	end

	// input transfer: predict the hit at acceptance
	always @(posedge clk) begin
		took <= query.valid && query.ready;
		if (arst_n && query.valid && query.ready) begin
			expected_hits.push_back(predict_hit(make_query(query.vertex_a, query.vertex_b,
				query.vertex_c, query.seg_start, query.seg_end)));
			n_taken <= n_taken + 1;
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		hit_t want;
		hit_t got;
		if (arst_n && result.valid && result.ready) begin
			got.hit_class = result.hit_class;
			got.weight_a  = result.weight_a;
			got.weight_b  = result.weight_b;
			got.weight_c  = result.weight_c;
			got.hit_x     = result.hit_x;
			got.hit_y     = result.hit_y;
			got.hit_z     = result.hit_z;
			if (expected_hits.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result transfer at %0t: class %0d", $realtime,
						got.hit_class);
			end else begin
				want = expected_hits.pop_front();
				// compare every field; a report prints each field as expected/actual
				if (got.hit_class !== want.hit_class || got.weight_a !== want.weight_a
					|| got.weight_b !== want.weight_b || got.weight_c !== want.weight_c
					|| got.hit_x !== want.hit_x || got.hit_y !== want.hit_y
					|| got.hit_z !== want.hit_z) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch at %0t: class %0d/%0d wa %0d/%0d wb %0d/%0d",
							$realtime, want.hit_class, got.hit_class, want.weight_a,
							got.weight_a, want.weight_b, got.weight_b);
						$display("  wc %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (expected/actual)",
							want.weight_c, got.weight_c, want.hit_x, got.hit_x,
							want.hit_y, got.hit_y, want.hit_z, got.hit_z);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- end of run

	initial begin
		wait (arst_n);
		wait (n_total > 0 && n_taken == n_total);
		wait (expected_hits.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0 && expected_hits.size() == 0)
			$display("PASS segment_triangle_intersect_top");
		else
			$display("FAIL segment_triangle_intersect_top");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL segment_triangle_intersect_top");
		$finish;
	end

endmodule
